// File: rtl/pts_pkg.sv
// Shared constants for the prime table sieve: default depths, field widths and codes.
// No dependencies; the top level takes this package in by a wildcard import.
package pts_pkg;

   localparam int DEF_SIEVE_DEPTH = 16384;
   localparam int DEF_TABLE_DEPTH = 4096;

   // A 12-bit index reaches this many table positions.
   localparam int INDEX_SPAN = 4096;

   localparam int BOUND_W = 14;
   localparam int INDEX_W = 12;
   localparam int VALUE_W = 14;
   localparam int COUNT_W = 13;

   localparam logic [BOUND_W-1:0] BOUND_RESET = 14'd50;

   localparam logic MODE_BUILD = 1'b0;
   localparam logic MODE_READ  = 1'b1;

endpackage

// File: rtl/prime_table_sieve_unit.sv
// Prime table sieve: builds a table of primes with the sieve of Eratosthenes and reads it back.
// Depends on pts_pkg for widths, defaults and request codes.
//
//   Channel   Direction  Handshake                Beat contents
//   req_      in         req_valid / req_ready    req_mode, req_index
//   rsp_      out        rsp_valid / rsp_ready    rsp_prime_value, rsp_prime_count, rsp_valid_res
//   csr_      in         csr_wr_en                csr_wr_data (prime bound)
//
// A read registers the table word at the accept edge, and S_RD loads the output register from
// it once that register is free. A build walks the bitmap through one port: it marks 2 to L,
// checks the flag of each i with i*i <= L and crosses out each prime i's multiples from i*i,
// then checks each number while packing, where L is the bound limited to SIEVE_DEPTH - 1.
// Reset is synchronous and no clearing pass follows it. A request is taken only when idle; a
// result waits in the output register while rsp_ready is low, and the sequencer holds behind it.
module prime_table_sieve_unit
   import pts_pkg::*;
#(
   parameter int SIEVE_DEPTH = DEF_SIEVE_DEPTH,
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [INDEX_W-1:0] req_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_prime_value,
   output logic [COUNT_W-1:0] rsp_prime_count,
   output logic               rsp_valid_res,
   input  logic               csr_wr_en,
   input  logic [BOUND_W-1:0] csr_wr_data
);

   localparam int SAW = $clog2(SIEVE_DEPTH);
   localparam int CW  = SAW + 1;
   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int CAP = (TABLE_DEPTH < INDEX_SPAN) ? TABLE_DEPTH : INDEX_SPAN;

   localparam logic [CW-1:0]      LIMIT_MAX = CW'(SIEVE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAP);
   localparam logic [CW-1:0]      FIRST_NUM = CW'(2);
   localparam logic [CW-1:0]      FIRST_SQ  = CW'(4);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RD     = 4'd1;
   localparam logic [3:0] S_FILL   = 4'd2;
   localparam logic [3:0] S_OREAD  = 4'd3;
   localparam logic [3:0] S_OCHECK = 4'd4;
   localparam logic [3:0] S_CROSS  = 4'd5;
   localparam logic [3:0] S_PREAD  = 4'd6;
   localparam logic [3:0] S_PCHK   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [BOUND_W-1:0] bound_ff, bound_in;
   logic [CW-1:0]      limit_ff, limit_in;
   logic [CW-1:0]      num_ff, num_in;
   logic [CW-1:0]      sq_ff, sq_in;
   logic [CW-1:0]      mult_ff, mult_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rd_ok_ff, rd_ok_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_res_ff, rsp_res_in;

   logic               sieve_mem [SIEVE_DEPTH];
   logic               sieve_rdata_ff;
   logic [SAW-1:0]     sieve_addr;
   logic               sieve_we;
   logic               sieve_wdata;

   logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];
   logic [VALUE_W-1:0] table_rdata_ff;
   logic [TAW-1:0]     table_raddr;
   logic               table_re;
   logic               table_we;

   logic               out_free;
   logic               accept;
   logic [31:0]        bound_wide;
   logic [31:0]        num_wide;
   logic [31:0]        index_wide;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign bound_wide = 32'(bound_ff);
   assign num_wide   = 32'(num_ff);
   assign index_wide = 32'(req_index);
   assign table_raddr = index_wide[TAW-1:0];
   assign table_re   = accept && (req_mode == MODE_READ);

   always_comb begin
      state_in     = state_ff;
      bound_in     = csr_wr_en ? csr_wr_data : bound_ff;
      limit_in     = limit_ff;
      num_in       = num_ff;
      sq_in        = sq_ff;
      mult_in      = mult_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_res_in   = rsp_res_ff;
      sieve_addr   = num_ff[SAW-1:0];
      sieve_we     = 1'b0;
      sieve_wdata  = 1'b1;
      table_we     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_READ) begin
                  rd_ok_in = ({1'b0, req_index} < count_ff);
                  state_in = S_RD;
               end else begin
                  if (bound_wide > 32'(LIMIT_MAX)) begin
                     limit_in = LIMIT_MAX;
                  end else begin
                     limit_in = bound_wide[CW-1:0];
                  end
                  num_in   = FIRST_NUM;
                  state_in = S_FILL;
               end
            end
         end
         S_RD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_ok_ff ? table_rdata_ff : '0;
               rsp_count_in = count_ff;
               rsp_res_in   = rd_ok_ff;
               state_in     = S_IDLE;
            end
         end
         S_FILL: begin
            if (num_ff > limit_ff) begin
               num_in   = FIRST_NUM;
               sq_in    = FIRST_SQ;
               state_in = S_OREAD;
            end else begin
               sieve_we = 1'b1;
               num_in   = num_ff + 1'b1;
            end
         end
         S_OREAD: begin
            // The bitmap is read here and the flag is seen in the next cycle.
            if (sq_ff > limit_ff) begin
               num_in   = FIRST_NUM;
               fill_in  = '0;
               state_in = S_PREAD;
            end else begin
               state_in = S_OCHECK;
            end
         end
         S_OCHECK: begin
            if (sieve_rdata_ff) begin
               mult_in  = sq_ff;
               state_in = S_CROSS;
            end else begin
               sq_in    = sq_ff + {num_ff[CW-2:0], 1'b1};
               num_in   = num_ff + 1'b1;
               state_in = S_OREAD;
            end
         end
         S_CROSS: begin
            if (mult_ff > limit_ff) begin
               sq_in    = sq_ff + {num_ff[CW-2:0], 1'b1};
               num_in   = num_ff + 1'b1;
               state_in = S_OREAD;
            end else begin
               sieve_addr  = mult_ff[SAW-1:0];
               sieve_we    = 1'b1;
               sieve_wdata = 1'b0;
               mult_in     = mult_ff + num_ff;
            end
         end
         S_PREAD: begin
            if ((num_ff > limit_ff) || (fill_ff >= CAP_COUNT)) begin
               count_in = fill_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (sieve_rdata_ff) begin
               table_we = 1'b1;
               fill_in  = fill_ff + 1'b1;
            end
            num_in   = num_ff + 1'b1;
            state_in = S_PREAD;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_count_in = count_ff;
               rsp_res_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bound_ff     <= BOUND_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bound_ff     <= bound_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff     <= limit_in;
      num_ff       <= num_in;
      sq_ff        <= sq_in;
      mult_ff      <= mult_in;
      fill_ff      <= fill_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_res_ff   <= rsp_res_in;
   end

   // Sieve bitmap: one port, registered read.
   always_ff @(posedge clock) begin
      if (sieve_we) begin
         sieve_mem[sieve_addr] <= sieve_wdata;
      end
      sieve_rdata_ff <= sieve_mem[sieve_addr];
   end

   // Prime table: written while packing, read for read requests.
   always_ff @(posedge clock) begin
      if (table_we) begin
         table_mem[fill_ff[TAW-1:0]] <= num_wide[VALUE_W-1:0];
      end
      if (table_re) begin
         table_rdata_ff <= table_mem[table_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_prime_count = rsp_count_ff;
   assign rsp_valid_res   = rsp_res_ff;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for prime_table_sieve_unit: a directed table, then random phases.
// Depends on rtl/pts_pkg.sv and rtl/prime_table_sieve_unit.sv; holds its own sieve predictor.
module tb;
   import pts_pkg::*;

   localparam int SIEVE_SIZE   = DEF_SIEVE_DEPTH;
   localparam int TABLE_CAP    = (DEF_TABLE_DEPTH < INDEX_SPAN) ? DEF_TABLE_DEPTH : INDEX_SPAN;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int BOUND_MAX    = (1 << BOUND_W) - 1;
   localparam int INDEX_MAX    = (1 << INDEX_W) - 1;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
      logic               valid;
   } prime_result_type;

   typedef struct {
      bit                 setup;
      logic [BOUND_W-1:0] bound;
      logic               mode;
      logic [INDEX_W-1:0] index;
      bit                 typed;
      prime_result_type   want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = MODE_BUILD;
   logic [INDEX_W-1:0] req_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [VALUE_W-1:0] rsp_prime_value;
   logic [COUNT_W-1:0] rsp_prime_count;
   logic               rsp_valid_res;
   logic               csr_wr_en = 1'b0;
   logic [BOUND_W-1:0] csr_wr_data = '0;

   // Predictor state.
   bit                 sieve_flags [SIEVE_SIZE];
   logic [VALUE_W-1:0] prime_list [TABLE_CAP];
   logic [COUNT_W-1:0] prime_total = '0;
   logic [BOUND_W-1:0] sieve_bound = BOUND_RESET;

   prime_result_type pending_results [$];
   stim_row_type     directed_rows [$];
   int               mismatch_count = 0;
   int               beats_checked = 0;
   int               cycle_count = 0;
   bit               steady_flow = 1'b0;

   prime_table_sieve_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_value (rsp_prime_value),
      .rsp_prime_count (rsp_prime_count),
      .rsp_valid_res   (rsp_valid_res),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(0, 99) >= 33);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH beat %0d %s: got %0d, expected %0d", beats_checked, what, got, want);
      mismatch_count++;
   endtask

   // Marks, crosses out and packs exactly as the block does, saturating the limit at the sieve.
   function automatic void build_primes();
      int lim;
      int n;
      lim = (int'(sieve_bound) > SIEVE_SIZE - 1) ? SIEVE_SIZE - 1 : int'(sieve_bound);
      n = 0;
      for (int i = 2; i <= lim; i++) sieve_flags[i] = 1'b1;
      for (int i = 2; i * i <= lim; i++)
         if (sieve_flags[i])
            for (int j = i * i; j <= lim; j += i) sieve_flags[j] = 1'b0;
      for (int i = 2; i <= lim && n < TABLE_CAP; i++) begin
         if (sieve_flags[i]) begin
            prime_list[n] = VALUE_W'(i);
            n++;
         end
      end
      prime_total = COUNT_W'(n);
   endfunction

   function automatic prime_result_type predict_prime_result(input logic mode,
                                                              input logic [INDEX_W-1:0] idx);
      prime_result_type r;
      r = '0;
      if (mode == MODE_BUILD) begin
         build_primes();
         r.valid = 1'b1;
      end else begin
         r.valid = (COUNT_W'(idx) < prime_total) && (int'(idx) < DEF_TABLE_DEPTH);
         if (r.valid) r.value = prime_list[idx];
      end
      r.count = prime_total;
      return r;
   endfunction

   always @(posedge clock) begin
      prime_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending", 32'(rsp_prime_count), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_prime_value !== want.value)
               report_mismatch("prime_value", 32'(rsp_prime_value), 32'(want.value));
            if (rsp_prime_count !== want.count)
               report_mismatch("prime_count", 32'(rsp_prime_count), 32'(want.count));
            if (rsp_valid_res !== want.valid)
               report_mismatch("valid_res", 32'(rsp_valid_res), 32'(want.valid));
         end
         beats_checked++;
      end
   end

   // Called just after a falling edge; returns just after the falling edge that follows
   // acceptance, leaving valid high so that a following beat needs no second assignment.
   task automatic send_beat(input logic mode, input logic [INDEX_W-1:0] idx, input bit typed,
                            input prime_result_type want);
      prime_result_type predicted;
      while (!steady_flow && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_prime_result(mode, idx);
      pending_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // The block is idle once every result has left, since it takes one request at a time.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_bound(input logic [BOUND_W-1:0] bound);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= bound;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sieve_bound = bound;
      @(negedge clock);
   endtask

   function automatic stim_row_type cfg_row(input int bound);
      stim_row_type r;
      r = '{setup: 1'b1, bound: BOUND_W'(bound), mode: MODE_BUILD, index: '0, typed: 1'b0,
            want: '0};
      return r;
   endfunction

   function automatic stim_row_type beat_row(input logic mode, input int idx,
                                             input int typed, input int value, input int count,
                                             input int ok);
      stim_row_type r;
      r = '{setup: 1'b0, bound: '0, mode: mode, index: INDEX_W'(idx), typed: (typed != 0),
            want: '{value: VALUE_W'(value), count: COUNT_W'(count), valid: (ok != 0)}};
      return r;
   endfunction

   function automatic logic [BOUND_W-1:0] pick_bound();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 6)  return BOUND_W'($urandom_range(0, 1));
      if (roll < 14) return BOUND_W'($urandom_range(2000, 10000));
      if (roll < 75) return BOUND_W'($urandom_range(2, 200));
      return BOUND_W'($urandom_range(200, 2000));
   endfunction

   initial begin
      int random_items;
      int phase;
      int burst;
      int roll;
      int idx;

      // Reads before any build see an empty table; the first build uses the reset bound of 50.
      directed_rows.push_back(beat_row(MODE_READ,  0,         1, 0,  0,  0));
      directed_rows.push_back(beat_row(MODE_READ,  INDEX_MAX, 1, 0,  0,  0));
      directed_rows.push_back(beat_row(MODE_BUILD, 0,         1, 0,  15, 1));
      directed_rows.push_back(beat_row(MODE_READ,  0,         1, 2,  15, 1));
      directed_rows.push_back(beat_row(MODE_READ,  14,        1, 47, 15, 1));
      directed_rows.push_back(beat_row(MODE_READ,  15,        1, 0,  15, 0));
      directed_rows.push_back(beat_row(MODE_READ,  INDEX_MAX, 1, 0,  15, 0));
      // Bounds below two leave the table empty.
      directed_rows.push_back(cfg_row(0));
      directed_rows.push_back(beat_row(MODE_BUILD, 0,         1, 0,  0,  1));
      directed_rows.push_back(beat_row(MODE_READ,  0,         1, 0,  0,  0));
      directed_rows.push_back(cfg_row(1));
      directed_rows.push_back(beat_row(MODE_BUILD, INDEX_MAX, 1, 0,  0,  1));
      directed_rows.push_back(cfg_row(2));
      directed_rows.push_back(beat_row(MODE_BUILD, 0,         1, 0,  1,  1));
      directed_rows.push_back(beat_row(MODE_READ,  0,         1, 2,  1,  1));
      directed_rows.push_back(beat_row(MODE_READ,  1,         1, 0,  1,  0));
      // The largest bound reaches the saturated sieve limit.
      directed_rows.push_back(cfg_row(BOUND_MAX));
      directed_rows.push_back(beat_row(MODE_BUILD, 'hAAA,     0, 0,  0,  0));
      directed_rows.push_back(beat_row(MODE_READ,  0,         0, 0,  0,  0));
      directed_rows.push_back(beat_row(MODE_READ,  1899,      0, 0,  0,  0));
      directed_rows.push_back(beat_row(MODE_READ,  1900,      0, 0,  0,  0));
      directed_rows.push_back(beat_row(MODE_READ,  'h555,     0, 0,  0,  0));
      directed_rows.push_back(beat_row(MODE_READ,  'hAAA,     0, 0,  0,  0));
      directed_rows.push_back(cfg_row(10000));
      directed_rows.push_back(beat_row(MODE_BUILD, 0,         0, 0,  0,  0));
      directed_rows.push_back(beat_row(MODE_READ,  1228,      0, 0,  0,  0));

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k]) begin
         if (directed_rows[k].setup) begin
            drain_results();
            write_bound(directed_rows[k].bound);
         end else begin
            send_beat(directed_rows[k].mode, directed_rows[k].index, directed_rows[k].typed,
                      directed_rows[k].want);
         end
      end

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         drain_results();
         steady_flow = (phase == 3 || phase == 4);
         write_bound(pick_bound());
         burst = $urandom_range(20, 60);
         send_beat(MODE_BUILD, INDEX_W'($urandom_range(0, 4095)), 1'b0, '0);
         random_items++;
         for (int k = 1; k < burst; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               // Hold the sender back until the block has emptied its pipeline.
               drain_results();
            end
            if (roll < 8) begin
               send_beat(MODE_BUILD, INDEX_W'($urandom_range(0, 4095)), 1'b0, '0);
            end else begin
               if (roll < 70 && prime_total != 0)
                  idx = $urandom_range(0, int'(prime_total) - 1);
               else if (roll < 85)
                  idx = int'(prime_total) + $urandom_range(0, 3);
               else
                  idx = $urandom_range(0, 4095);
               if (idx > 4095) idx = 4095;
               send_beat(MODE_READ, INDEX_W'(idx), 1'b0, '0);
            end
            random_items++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      steady_flow = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", 0, pending_results.size());

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
